>>> design/pptk_pkg.sv
// Shared types and constants for the polar point top-k keeper.
// Holds the controller-to-datapath command word and the Q1.16 sine table.
package pptk_pkg;

  // Default number of kept points
  localparam int KEEP_COUNT_DEF = 4;

  // Angle constants in whole degrees
  localparam logic [8:0] FULL_TURN    = 9'd360;
  localparam logic [8:0] HALF_TURN    = 9'd180;
  localparam logic [8:0] QUARTER_TURN = 9'd90;
  localparam logic [8:0] THREE_QUARTER_TURN = 9'd270;

  // Fraction bits of the sine table
  localparam int FRAC_BITS = 16;

  // Quarter-wave sine, round(sin(d) * 65536), d = 0..90
  localparam logic [16:0] SINE_Q16 [0:90] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch a new input word
    logic mul_en;     // run the shared multiplier this cycle
    logic mul_cos;    // multiplier works on the cosine (grid x) this cycle
    logic scan_first; // first step of the minimum search
    logic scan_step;  // compare one more slot against the running minimum
    logic finish;     // update the slots and present the result word
  } pptk_cmd_t;

endpackage

>>> design/pptk_ctrl.sv
// Controller for the polar point top-k keeper: sequences capture,
// multiply, slot scan and finish. Depends on pptk_pkg.
module pptk_ctrl #(
  parameter int KEEP_COUNT = pptk_pkg::KEEP_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output pptk_pkg::pptk_cmd_t cmd
);
  import pptk_pkg::*;

  // Work state length: room for the two multiplies and for one slot compare per slot after the first
  localparam int WORK_CYCLES = (KEEP_COUNT - 1 > 2) ? KEEP_COUNT - 1 : 2;
  localparam int CNT_W       = (WORK_CYCLES > 1) ? $clog2(WORK_CYCLES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORK_CYCLES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign busy   = (state_r == ST_WORK);
  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          state_nxt = ST_WORK;
          cnt_nxt   = '0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WORK: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Decode commands
  always_comb begin
    cmd            = '0;
    cmd.capture    = accept;
    cmd.finish     = (state_r == ST_DONE);
    if (state_r == ST_WORK) begin
      cmd.scan_step  = 1'b1;
      cmd.scan_first = (cnt_r == '0);
      cmd.mul_en     = (cnt_r == '0) || (cnt_r == CNT_W'(1));
      cmd.mul_cos    = (cnt_r == CNT_W'(1));
    end
  end

endmodule

>>> design/pptk_dp.sv
// Datapath for the polar point top-k keeper: shared sine multiplier,
// kept-slot registers, minimum scan and result register. Depends on pptk_pkg.
module pptk_dp #(
  parameter int KEEP_COUNT = pptk_pkg::KEEP_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pptk_pkg::pptk_cmd_t cmd,
  input  logic [15:0]         in_distance,
  input  logic [8:0]          in_angle_deg,
  output logic                out_valid,
  output logic signed [16:0]  out_grid_x,
  output logic signed [16:0]  out_grid_y,
  output logic                out_kept,
  output logic [1:0]          out_slot
);
  import pptk_pkg::*;

  localparam int IDX_W  = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
  localparam int FILL_W = $clog2(KEEP_COUNT + 1);
  localparam int WORK_CYCLES = (KEEP_COUNT - 1 > 2) ? KEEP_COUNT - 1 : 2;
  localparam int SCN_W  = $clog2(WORK_CYCLES + 2);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(KEEP_COUNT);
  localparam logic [SCN_W-1:0]  SCN_END   = SCN_W'(KEEP_COUNT);

  // Input word
  logic [15:0] dist_r;
  logic [8:0]  ang_r;

  // Kept points
  logic [16:0]       kept_x_r        [KEEP_COUNT];
  logic [16:0]       kept_y_r        [KEEP_COUNT];
  logic [15:0]       kept_distance_r [KEEP_COUNT];
  logic [8:0]        kept_angle_r    [KEEP_COUNT];
  logic [FILL_W-1:0] fill_count_r;

  // Computation registers
  logic [16:0]      gx_r, gy_r;
  logic [SCN_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] min_idx_r, min_idx_nxt;
  logic [15:0]      min_dist_r, min_dist_nxt;

  // Result word
  logic        out_valid_r;
  logic [16:0] out_x_r, out_y_r;
  logic        out_kept_r;
  logic [1:0]  out_slot_r;

  // Multiplier path
  logic [9:0]  cos_sum;
  logic [8:0]  cos_ang, mul_ang, fold_ang;
  logic [6:0]  tab_idx;
  logic        tab_neg;
  logic [16:0] tab_val;
  logic [32:0] prod;
  logic [16:0] mag, sval;

  // Finish decision
  logic             full;
  logic             take;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      wr_idx_ext;
  logic [IDX_W-1:0] cand_idx;
  logic [15:0]      cur_dist;
  logic [IDX_W-1:0] cur_idx;

  // Cosine is the sine of the angle advanced by a quarter turn
  assign cos_sum = {1'b0, ang_r} + {1'b0, QUARTER_TURN};
  assign cos_ang = (cos_sum >= {1'b0, FULL_TURN}) ? 9'(cos_sum - {1'b0, FULL_TURN})
                                                  : cos_sum[8:0];
  assign mul_ang = cmd.mul_cos ? cos_ang : ang_r;

  // Fold into the first quadrant and note the sign
  always_comb begin
    if (mul_ang <= QUARTER_TURN) begin
      fold_ang = mul_ang;
      tab_neg  = 1'b0;
    end else if (mul_ang <= HALF_TURN) begin
      fold_ang = HALF_TURN - mul_ang;
      tab_neg  = 1'b0;
    end else if (mul_ang <= THREE_QUARTER_TURN) begin
      fold_ang = mul_ang - HALF_TURN;
      tab_neg  = 1'b1;
    end else begin
      fold_ang = FULL_TURN - mul_ang;
      tab_neg  = 1'b1;
    end
    tab_idx = fold_ang[6:0];
  end

  assign tab_val = SINE_Q16[tab_idx];
  assign prod    = 33'(dist_r) * 33'(tab_val);
  assign mag     = prod[32:FRAC_BITS];
  assign sval    = tab_neg ? (17'd0 - mag) : mag;

  // Minimum scan: one slot compare per step, lowest index wins a tie
  assign cand_idx = scan_idx_r[IDX_W-1:0];
  assign cur_dist = cmd.scan_first ? kept_distance_r[0] : min_dist_r;
  assign cur_idx  = cmd.scan_first ? '0 : min_idx_r;

  always_comb begin
    min_idx_nxt  = cur_idx;
    min_dist_nxt = cur_dist;
    if ((scan_idx_r < SCN_END) && (kept_distance_r[cand_idx] < cur_dist)) begin
      min_idx_nxt  = cand_idx;
      min_dist_nxt = kept_distance_r[cand_idx];
    end
  end

  // Decide whether the point is kept and where it goes
  assign full       = (fill_count_r == FILL_FULL);
  assign take       = full ? (min_dist_r < dist_r) : 1'b1;
  assign wr_idx     = full ? min_idx_r : fill_count_r[IDX_W-1:0];
  assign wr_idx_ext = 32'(wr_idx);

  // Capture input, run multiplier and scan
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dist_r <= in_distance;
      ang_r  <= (in_angle_deg >= FULL_TURN) ? (in_angle_deg - FULL_TURN) : in_angle_deg;
    end
    if (cmd.mul_en) begin
      if (cmd.mul_cos) begin
        gx_r <= sval;
      end else begin
        gy_r <= sval;
      end
    end
    if (cmd.capture) begin
      scan_idx_r <= SCN_W'(1);
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + SCN_W'(1);
    end
    if (cmd.scan_step) begin
      min_idx_r  <= min_idx_nxt;
      min_dist_r <= min_dist_nxt;
    end
    if (cmd.finish) begin
      out_x_r    <= gx_r;
      out_y_r    <= gy_r;
      out_kept_r <= take;
      out_slot_r <= wr_idx_ext[1:0];
    end
  end

  // Update kept slots and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < KEEP_COUNT; i++) begin
        kept_x_r[i]        <= '0;
        kept_y_r[i]        <= '0;
        kept_distance_r[i] <= '0;
        kept_angle_r[i]    <= '0;
      end
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.finish && !full) begin
        fill_count_r <= fill_count_r + FILL_W'(1);
      end
      if (cmd.finish && take) begin
        kept_x_r[wr_idx]        <= gx_r;
        kept_y_r[wr_idx]        <= gy_r;
        kept_distance_r[wr_idx] <= dist_r;
        kept_angle_r[wr_idx]    <= ang_r;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_grid_x = out_x_r;
  assign out_grid_y = out_y_r;
  assign out_kept   = out_kept_r;
  assign out_slot   = out_slot_r;

endmodule

>>> design/polar_point_top_k_keeper_unit.sv
// Polar point top-k keeper: converts a range reading to grid x/y and keeps
// the KEEP_COUNT farthest points. After start is taken, the work state runs the one
// shared multiplier for sine then cosine alongside the slot-by-slot minimum scan;
// the finish step then updates the slots and the result word is registered from it.
// A new word is taken only while busy is low, which includes the finish step.
// Reset (rst_n low, synchronous) empties all slots; results cannot be stalled.
module polar_point_top_k_keeper_unit #(
  parameter int KEEP_COUNT = pptk_pkg::KEEP_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_distance,
  input  logic [8:0]         in_angle_deg,
  output logic               out_valid,
  output logic signed [16:0] out_grid_x,
  output logic signed [16:0] out_grid_y,
  output logic               out_kept,
  output logic [1:0]         out_slot
);
  import pptk_pkg::*;

  pptk_cmd_t cmd;

  // Sequence each word
  pptk_ctrl #(
    .KEEP_COUNT(KEEP_COUNT)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .cmd  (cmd)
  );

  // Compute and keep points
  pptk_dp #(
    .KEEP_COUNT(KEEP_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_distance (in_distance),
    .in_angle_deg(in_angle_deg),
    .out_valid   (out_valid),
    .out_grid_x  (out_grid_x),
    .out_grid_y  (out_grid_y),
    .out_kept    (out_kept),
    .out_slot    (out_slot)
  );

  // Finish always yields a result strobe on the next cycle
  a_finish_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finish step did not raise the result strobe");

  // A taken word makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("unit not busy after taking a word");

  // Results never come on consecutive cycles
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes on back-to-back cycles");

endmodule

>>> bench/tb_polar_point_top_k_keeper_unit.sv
// Self-checking bench for polar_point_top_k_keeper_unit: polar-to-grid conversion and the
// four-slot farthest-point keeper, checked word by word against an in-bench predictor.
// Depends on pptk_pkg (angle constants, Q1.16 sine table) and the unit itself.
`timescale 1ns / 1ps

module tb_polar_point_top_k_keeper_unit;
  import pptk_pkg::*;

  localparam int SLOTS = KEEP_COUNT_DEF;
  localparam int RANDOM_READINGS = 1530;

  typedef struct {
    logic [15:0] distance;
    logic [8:0]  angle;
    int          idle_after;
    bit          drain_before;
  } reading_t;

  typedef struct {
    logic signed [16:0] grid_x;
    logic signed [16:0] grid_y;
    logic               kept;
    logic [1:0]         slot;
  } point_verdict_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [15:0]        in_distance = '0;
  logic [8:0]         in_angle_deg = '0;
  logic               out_valid;
  logic signed [16:0] out_grid_x;
  logic signed [16:0] out_grid_y;
  logic               out_kept;
  logic [1:0]         out_slot;

  reading_t       reading_q[$];
  point_verdict_t verdict_q[$];

  // predictor copy of the kept distances and the fill level
  logic [15:0] held_dist [SLOTS];
  int          filled = 0;

  int idle_left = 0;
  bit word_taken = 1'b0;
  int planned_total = 0;
  int taken_total = 0;
  int checked_total = 0;
  int kept_total = 0;
  int wrapped_total = 0;
  int mismatch_count = 0;

  always #2 clk = ~clk;

  polar_point_top_k_keeper_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_distance  (in_distance),
    .in_angle_deg (in_angle_deg),
    .out_valid    (out_valid),
    .out_grid_x   (out_grid_x),
    .out_grid_y   (out_grid_y),
    .out_kept     (out_kept),
    .out_slot     (out_slot)
  );

  // distance * sin(a), truncated toward zero, for a bearing below a full turn
  function automatic logic signed [16:0] scaled_trig(logic [15:0] meas, logic [8:0] a);
    logic [8:0]  idx;
    bit          neg;
    logic [32:0] prod;
    logic [16:0] mag;
    if (a <= QUARTER_TURN) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= HALF_TURN) begin
      idx = HALF_TURN - a;
      neg = 1'b0;
    end else if (a <= THREE_QUARTER_TURN) begin
      idx = a - HALF_TURN;
      neg = 1'b1;
    end else begin
      idx = FULL_TURN - a;
      neg = 1'b1;
    end
    prod = meas * SINE_Q16[idx];
    mag = prod[32:16];
    return $signed(neg ? -mag : mag);
  endfunction

  // lowest-indexed slot holding the smallest distance
  function automatic int weakest_slot();
    int s;
    s = 0;
    for (int i = 1; i < SLOTS; i++) begin
      if (held_dist[i] < held_dist[s]) s = i;
    end
    return s;
  endfunction

  // work out the result word for one accepted reading and update the kept set
  function automatic void place_point(logic [15:0] meas, logic [8:0] raw_angle);
    logic [8:0]     ang;
    logic [8:0]     cos_ang;
    point_verdict_t v;
    int             s;
    ang = raw_angle;
    if (raw_angle >= FULL_TURN) begin
      ang = raw_angle - FULL_TURN;
      wrapped_total++;
    end
    cos_ang = ang + QUARTER_TURN;
    if (cos_ang >= FULL_TURN) cos_ang = cos_ang - FULL_TURN;
    v.grid_y = scaled_trig(meas, ang);
    v.grid_x = scaled_trig(meas, cos_ang);
    if (filled < SLOTS) begin
      s = filled;
      filled++;
      v.kept = 1'b1;
    end else begin
      s = weakest_slot();
      v.kept = held_dist[s] < meas;
    end
    if (v.kept) begin
      held_dist[s] = meas;
      kept_total++;
    end
    v.slot = s[1:0];
    verdict_q.push_back(v);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic queue_reading(int meas, int ang, int idle, bit drain);
    reading_t r;
    r.distance = meas[15:0];
    r.angle = ang[8:0];
    r.idle_after = idle;
    r.drain_before = drain;
    reading_q.push_back(r);
    planned_total++;
  endtask

  // check result words, then record the word taken at this edge
  always @(posedge clk) begin : watch
    point_verdict_t want;
    word_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with none expected, actual x=%0d y=%0d kept=%0d slot=%0d",
                   $time, out_grid_x, out_grid_y, out_kept, out_slot);
        end else begin
          want = verdict_q.pop_front();
          check_field("grid_x", int'(want.grid_x), int'(out_grid_x));
          check_field("grid_y", int'(want.grid_y), int'(out_grid_y));
          check_field("kept", int'(want.kept), int'(out_kept));
          check_field("slot", int'(want.slot), int'(out_slot));
          checked_total++;
        end
      end
      if (start && !busy) begin
        place_point(in_distance, in_angle_deg);
        taken_total++;
      end
    end
  end

  // drive the next word at the falling edge; hold it until the unit takes it
  always @(negedge clk) begin : feed
    reading_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
      // hold the current word
    end else if (idle_left > 0) begin
      start <= 1'b0;
      in_distance <= 16'($urandom);
      in_angle_deg <= 9'($urandom);
      idle_left <= idle_left - 1;
    end else if (reading_q.size() > 0 &&
                 !(reading_q[0].drain_before && verdict_q.size() > 0)) begin
      r = reading_q.pop_front();
      start <= 1'b1;
      in_distance <= r.distance;
      in_angle_deg <= r.angle;
      idle_left <= r.idle_after;
    end else begin
      start <= 1'b0;
    end
  end

  initial begin : run
    int m;
    int meas;
    int ang;
    int idle;
    int pick;
    for (int i = 0; i < SLOTS; i++) held_dist[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the slots in order, including zero and full-scale distances
    queue_reading(0, 0, 0, 0);
    queue_reading(65535, 90, 3, 0);
    queue_reading(65535, 180, 0, 0);
    queue_reading(3, 270, 1, 0);
    // equal to the minimum: dropped
    queue_reading(0, 359, 0, 0);
    // bearing of a full turn wraps to zero
    queue_reading(1, 360, 2, 0);
    queue_reading(1, 511, 0, 0);
    queue_reading(0, 45, 0, 0);
    queue_reading(3, 450, 0, 0);
    // tie on the minimum between two slots, new distance equal: dropped
    queue_reading(3, 135, 0, 0);
    // tie on the minimum: lowest slot is replaced
    queue_reading(4, 225, 0, 1);
    queue_reading(4, 315, 5, 0);
    queue_reading(2, 1, 0, 0);
    // quadrant edges on the conversion
    queue_reading(32768, 89, 0, 0);
    queue_reading(12345, 91, 0, 0);
    queue_reading(54321, 179, 12, 0);
    queue_reading(777, 181, 0, 0);
    queue_reading(1000, 269, 0, 0);
    queue_reading(40000, 271, 0, 0);

    // random readings steered around the current minimum so both outcomes stay common
    for (int n = 0; n < RANDOM_READINGS; n++) begin
      while (reading_q.size() > 1) begin
        @(negedge clk);
        #1;
      end
      m = held_dist[weakest_slot()];
      pick = $urandom_range(0, 99);
      if (pick < 35) meas = m;
      else if (pick < 65) meas = (m + $urandom_range(1, 16) > 65535) ? 65535 :
                                 m + $urandom_range(1, 16);
      else if (pick < 85) meas = $urandom_range(0, m);
      else meas = $urandom_range(0, 65535);
      ang = ($urandom_range(0, 6) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
      idle = 0;
      if ((n < 600 || n >= 750) && n < RANDOM_READINGS - 150 && $urandom_range(0, 3) == 0)
        idle = $urandom_range(1, 12);
      queue_reading(meas, ang, idle, (n % 400) == 399);
    end

    wait (taken_total == planned_total);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Readings taken: %0d, result words checked: %0d", taken_total, checked_total);
    $display("Points kept: %0d, bearings past a full turn: %0d", kept_total, wrapped_total);
    if (mismatch_count == 0) begin
      $display("[polar_point_top_k_keeper_unit] OK");
    end else begin
      $display("[polar_point_top_k_keeper_unit] ERROR");
    end
    $finish;
  end

  // stop a hung run
  initial begin : watchdog
    #2000000;
    $display("[polar_point_top_k_keeper_unit] ERROR");
    $finish;
  end

endmodule
